/* rtl/ttp_pkg.sv */
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared types, constants and unit table for the timeout text parser.
// ----------------------------------------------------------------------------
package ttp_pkg;

  localparam int unsigned VALUE_W = 27;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned PER_W   = 42;
  localparam int unsigned NS_W    = 63;

  // Split of the held value for the two partial products
  localparam int unsigned LO_W = 14;
  localparam int unsigned HI_W = VALUE_W - LO_W;

  localparam logic [COUNT_W-1:0] MAX_DIGITS       = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_SATURATION = 4'd9;

  // Largest value whose product with one hour still fits a signed 64-bit count
  localparam logic [VALUE_W-1:0] HOURS_MAX_VALUE = 27'd2562047;

  localparam logic [PER_W-1:0] NS_PER_HOUR   = 42'd3600000000000;
  localparam logic [PER_W-1:0] NS_PER_MINUTE = 42'd60000000000;
  localparam logic [PER_W-1:0] NS_PER_SECOND = 42'd1000000000;
  localparam logic [PER_W-1:0] NS_PER_MILLI  = 42'd1000000;
  localparam logic [PER_W-1:0] NS_PER_MICRO  = 42'd1000;
  localparam logic [PER_W-1:0] NS_PER_NANO   = 42'd1;

  typedef enum logic [2:0] {
    UNIT_NONE,
    UNIT_HOUR,
    UNIT_MINUTE,
    UNIT_SECOND,
    UNIT_MILLI,
    UNIT_MICRO,
    UNIT_NANO
  } ttp_unit_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ttp_in_t;

  typedef struct packed {
    logic            ok;
    logic [NS_W-1:0] nanoseconds;
  } ttp_out_t;

  // Parsed text handed to the multiplier; value is zero when rejected
  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
    ttp_unit_t          unit;
  } ttp_job_t;

  function automatic logic [PER_W-1:0] unit_size(input ttp_unit_t unit);
    logic [PER_W-1:0] per;
    case (unit)
      UNIT_HOUR:   per = NS_PER_HOUR;
      UNIT_MINUTE: per = NS_PER_MINUTE;
      UNIT_SECOND: per = NS_PER_SECOND;
      UNIT_MILLI:  per = NS_PER_MILLI;
      UNIT_MICRO:  per = NS_PER_MICRO;
      UNIT_NANO:   per = NS_PER_NANO;
      default:     per = '0;
    endcase
    return per;
  endfunction

endpackage

/* rtl/ttp_front.sv */
// ----------------------------------------------------------------------------
// ttp_front
// Input register, digit accumulator and unit decode. Emits one parse job
// for each character marked last.
// ----------------------------------------------------------------------------
module ttp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttp_pkg::ttp_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output ttp_pkg::ttp_job_t job
);
  import ttp_pkg::*;

  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_HOUR   = "H";
  localparam logic [7:0] CH_MINUTE = "M";
  localparam logic [7:0] CH_SECOND = "S";
  localparam logic [7:0] CH_MILLI  = "m";
  localparam logic [7:0] CH_MICRO  = "u";
  localparam logic [7:0] CH_NANO   = "n";

  logic               in_v_r;
  ttp_in_t            in_r;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               bad_r, bad_nxt;
  logic               job_v_r;
  ttp_job_t           job_r, job_nxt;

  logic               job_free;
  logic               in_go;
  logic               is_digit;
  logic [7:0]         digit;
  logic [VALUE_W-1:0] acc_x10;
  ttp_unit_t          unit;
  logic               fits;

  assign job_free = !job_v_r || job_ready;
  // A digit beat only updates state; a unit beat needs room for its job
  assign in_go    = in_v_r && (!in_r.last || job_free);
  assign in_ready = !in_v_r || in_go;

  assign is_digit = (in_r.ch >= CH_ZERO) && (in_r.ch <= CH_NINE);
  assign digit    = in_r.ch - CH_ZERO;
  assign acc_x10  = (acc_r << 3) + (acc_r << 1);

  always_comb begin
    case (in_r.ch)
      CH_HOUR:   unit = UNIT_HOUR;
      CH_MINUTE: unit = UNIT_MINUTE;
      CH_SECOND: unit = UNIT_SECOND;
      CH_MILLI:  unit = UNIT_MILLI;
      CH_MICRO:  unit = UNIT_MICRO;
      CH_NANO:   unit = UNIT_NANO;
      default:   unit = UNIT_NONE;
    endcase
  end

  always_comb begin
    fits = !bad_r && (cnt_r != '0) && (cnt_r <= MAX_DIGITS) && (unit != UNIT_NONE)
           && ((unit != UNIT_HOUR) || (acc_r <= HOURS_MAX_VALUE));
    job_nxt.ok    = fits;
    job_nxt.value = fits ? acc_r : '0;
    job_nxt.unit  = unit;
  end

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    bad_nxt = bad_r;
    if (in_go) begin
      if (in_r.last) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        bad_nxt = 1'b0;
      end else if (is_digit) begin
        if (cnt_r < MAX_DIGITS) begin
          acc_nxt = acc_x10 + VALUE_W'(digit[3:0]);
        end
        if (cnt_r < COUNT_SATURATION) begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      bad_r   <= 1'b0;
      job_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
      if (job_free) begin
        job_v_r <= in_go && in_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (job_free) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_v_r;
  assign job       = job_r;

endmodule

/* rtl/ttp_mult.sv */
// ----------------------------------------------------------------------------
// ttp_mult
// Scales the parsed value by the unit size: two registered partial
// products, then a registered sum that forms the result beat.
// ----------------------------------------------------------------------------
module ttp_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  ttp_pkg::ttp_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output ttp_pkg::ttp_out_t out_data
);
  import ttp_pkg::*;

  localparam int unsigned LO_P_W = LO_W + PER_W;
  localparam int unsigned HI_P_W = HI_W + PER_W;

  logic              part_v_r;
  logic              part_ok_r;
  logic [LO_P_W-1:0] lo_r, lo_nxt;
  logic [HI_P_W-1:0] hi_r, hi_nxt;
  logic              out_v_r;
  ttp_out_t          out_r, out_nxt;

  logic [PER_W-1:0]  per;
  logic              out_ld;
  logic              part_free;

  assign out_ld    = part_v_r && (!out_v_r || out_ready);
  assign part_free = !part_v_r || out_ld;
  assign job_ready = part_free;

  assign per    = unit_size(job.unit);
  assign lo_nxt = LO_P_W'(job.value[LO_W-1:0]) * LO_P_W'(per);
  assign hi_nxt = HI_P_W'(job.value[VALUE_W-1:LO_W]) * HI_P_W'(per);

  // Overflow was ruled out upstream, so the sum fits in 63 bits
  always_comb begin
    out_nxt.ok          = part_ok_r;
    out_nxt.nanoseconds = NS_W'({hi_r, {LO_W{1'b0}}}) + NS_W'(lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (part_free) begin
        part_v_r <= job_valid;
      end
      if (out_ld) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_free && job_valid) begin
      part_ok_r <= job.ok;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
    end
    if (out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* rtl/timeout_text_parser.sv */
// ----------------------------------------------------------------------------
// timeout_text_parser
// Parses a timeout text (digits then a unit letter) into nanoseconds.
// ----------------------------------------------------------------------------
// One character is taken per beat and a new beat can be accepted every
// cycle unless a unit beat stalls. Digit beats update the running value
// and produce nothing; the beat marked last is the unit (H, M, S, m, u, n)
// and yields one result beat with ok and the duration in nanoseconds (zero
// when rejected). From the input register a result passes registered decode
// and check, partial products and final sum. Throughput is one character
// per cycle, set by the multiply-by-ten accumulate in the front end. A
// stalled output holds the pipeline only as far back as it is full.
// ----------------------------------------------------------------------------
module timeout_text_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttp_pkg::ttp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ttp_pkg::ttp_out_t out_data
);
  import ttp_pkg::*;

  logic     job_valid;
  logic     job_ready;
  ttp_job_t job;

  ttp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  ttp_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
